// ===== rtl/png_row_unfilter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the row unfilter checker
// ----------------------------------------------------------------------------
`ifndef PNG_ROW_UNFILTER_ASSERT_SVH
`define PNG_ROW_UNFILTER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define PRU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("png_row_unfilter: assertion failed");

// next-cycle implication, off while reset is asserted
`define PRU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("png_row_unfilter: assertion failed");

`endif

// ===== rtl/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants of the PNG row unfilter.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int MAX_ROW_BYTES   = 4096;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int IDX_W           = $clog2(MAX_ROW_BYTES);
  localparam int POS_W           = IDX_W + 1;
  localparam int PIX_IDX_W       = $clog2(MAX_PIXEL_BYTES);
  localparam int BPP_W           = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 13;

  localparam logic [7:0] TAG_NONE  = 8'h30;
  localparam logic [7:0] TAG_PAETH = 8'h34;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
    filt_e            kind;
    logic             bad;
    logic             first;
    logic             left_ok;
  } item_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
    logic       bad;
  } result_t;

endpackage

// ===== rtl/pru_front.sv =====
// ----------------------------------------------------------------------------
// pru_front
// Accepts tag and data bytes, tracks the row position and issues one work
// item per data byte.
// ----------------------------------------------------------------------------
module pru_front import pru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_data_i,
  input  logic             in_first_i,
  input  logic [POS_W-1:0] row_len_i,
  input  logic [BPP_W-1:0] bpp_i,
  input  logic             q_ready_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  filt_e            kind_q, kind_d;
  logic             bad_q, bad_d;
  logic             first_q, first_d;

  logic             is_tag;
  logic             accept;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] idx;
  logic             last;

  assign is_tag     = (pos_q == '0);
  assign in_ready_o = is_tag || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_m1 = pos_q - 1'b1;
  assign idx    = (pos_m1 >= POS_W'(MAX_ROW_BYTES)) ? IDX_W'(MAX_ROW_BYTES - 1)
                                                    : pos_m1[IDX_W-1:0];
  assign last   = ({1'b0, idx} + 1'b1) >= row_len_i;

  assign q_push_o         = accept && !is_tag;
  assign q_item_o.data    = in_data_i;
  assign q_item_o.idx     = idx;
  assign q_item_o.last    = last;
  assign q_item_o.kind    = kind_q;
  assign q_item_o.bad     = bad_q;
  assign q_item_o.first   = first_q;
  assign q_item_o.left_ok = {1'b0, idx} >= POS_W'(bpp_i);

  always_comb begin
    pos_d   = pos_q;
    kind_d  = kind_q;
    bad_d   = bad_q;
    first_d = first_q;
    if (accept) begin
      if (is_tag) begin
        if (in_data_i >= TAG_NONE && in_data_i <= TAG_PAETH) begin
          kind_d = filt_e'(3'(in_data_i - TAG_NONE));
          bad_d  = 1'b0;
        end else begin
          kind_d = FILT_NONE;
          bad_d  = 1'b1;
        end
        first_d = in_first_i;
        pos_d   = POS_W'(1);
      end else begin
        pos_d = last ? '0 : ({1'b0, idx} + POS_W'(2));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      kind_q  <= FILT_NONE;
      bad_q   <= 1'b0;
      first_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      bad_q   <= bad_d;
      first_q <= first_d;
    end
  end

endmodule

// ===== rtl/pru_fifo.sv =====
// ----------------------------------------------------------------------------
// pru_fifo
// Two-entry queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module pru_fifo import pru_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_item_o
);

  item_t      slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/pru_back.sv =====
// ----------------------------------------------------------------------------
// pru_back
// Reads the prior row, applies the row filter, keeps the pixel history and
// writes the rebuilt row back; holds the result in an output register.
// ----------------------------------------------------------------------------
module pru_back import pru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  input  logic [BPP_W-1:0] bpp_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_res_o
);

  logic [7:0] mem_q [MAX_ROW_BYTES];
  logic [7:0] rdata_q;
  logic       fwd_q;
  logic [7:0] fwd_data_q;

  logic       r_valid_q;
  item_t      r_q;
  logic       o_valid_q;
  result_t    res_q;

  logic [7:0] lh_q [MAX_PIXEL_BYTES];
  logic [7:0] ul_q [MAX_PIXEL_BYTES];

  logic             adv;
  logic             load_r;
  logic             wr_en;
  logic [BPP_W-1:0] bpp_m1;
  logic [7:0]       up, a, c, pred, raw;
  logic [8:0]       avg_sum;
  logic signed [10:0] pa, pb, pc;

  function automatic logic signed [10:0] abs11(input logic signed [10:0] v);
    abs11 = (v < 0) ? -v : v;
  endfunction

  assign adv     = r_valid_q && (!o_valid_q || out_ready_i);
  assign load_r  = q_valid_i && (!r_valid_q || adv);
  assign q_pop_o = load_r;
  assign wr_en   = adv && !r_q.bad;

  assign bpp_m1  = bpp_i - 1'b1;
  assign up      = r_q.first ? 8'd0 : (fwd_q ? fwd_data_q : rdata_q);
  assign a       = r_q.left_ok ? lh_q[bpp_m1[PIX_IDX_W-1:0]] : 8'd0;
  assign c       = r_q.left_ok ? ul_q[bpp_m1[PIX_IDX_W-1:0]] : 8'd0;
  assign avg_sum = {1'b0, a} + {1'b0, up};

  assign pa = abs11($signed({3'b000, up}) - $signed({3'b000, c}));
  assign pb = abs11($signed({3'b000, a}) - $signed({3'b000, c}));
  assign pc = abs11($signed({3'b000, a}) + $signed({3'b000, up})
                    - $signed({2'b00, c, 1'b0}));

  always_comb begin
    unique case (r_q.kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = up;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
  end

  assign raw = r_q.data + pred;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[r_q.idx] <= raw;
    end
    if (load_r) begin
      rdata_q    <= mem_q[q_item_i.idx];
      fwd_q      <= wr_en && (r_q.idx == q_item_i.idx);
      fwd_data_q <= raw;
      r_q        <= q_item_i;
    end
    if (adv) begin
      ul_q[0]   <= up;
      lh_q[0]   <= r_q.bad ? 8'd0 : raw;
      res_q.raw  <= r_q.bad ? 8'd0 : raw;
      res_q.last <= r_q.last;
      res_q.bad  <= r_q.bad;
      for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
        ul_q[k] <= ul_q[k-1];
        lh_q[k] <= lh_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (!r_valid_q || adv) begin
        r_valid_q <= q_valid_i;
      end
      if (!o_valid_q || out_ready_i) begin
        o_valid_q <= r_valid_q;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/png_row_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_row_unfilter
// PNG scanline reconstruction, one filtered byte in and one raw byte out.
// ----------------------------------------------------------------------------
// Slave stream: one byte per transaction. The first byte of each row is the
// filter tag ('0'..'4'); tuser carries first_row with it. The tag yields no
// output; every following data byte yields one master transaction with the
// raw byte, tlast on the last byte of the row and tuser set when the tag was
// unknown (data then reads zero and the line store is left alone).
// Configuration: write row_bytes (index 0) and bytes_per_pixel (index 1)
// while the stream is idle; cfg_ready_o is always high.
// Throughput: one byte per cycle while the receiver is ready, set by the single
// add plus Paeth select that closes the left-neighbor loop in the back stage.
// Each byte passes in turn through the queue, the line-store read and the
// compute into the output register.
// Reset clears row position, tag state and all valid flags; the line store
// has no clearing pass and must be filled by a first row before it is used.
// When the receiver stalls, the output register holds, the two-entry queue
// fills, and s_axis_tready_o drops for data bytes.
// ----------------------------------------------------------------------------
module png_row_unfilter import pru_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]            s_axis_tuser_i,   // [0] first_row
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // [7:0] raw_byte
  output logic                  m_axis_tlast_o,
  output logic [0:0]            m_axis_tuser_o,   // [0] bad_filter
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DATA_W-1:0] row_bytes_q;
  logic [BPP_W-1:0]      bpp_q;
  logic [POS_W-1:0]      row_len;
  logic [BPP_W-1:0]      bpp_eff;

  logic    q_ready, q_push, q_valid, q_pop;
  item_t   push_item, pop_item;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= CFG_DATA_W'(1);
      bpp_q       <= BPP_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW_BYTES:   row_bytes_q <= cfg_data_i;
        CFG_PIXEL_BYTES: bpp_q       <= cfg_data_i[BPP_W-1:0];
        default:         row_bytes_q <= row_bytes_q;
      endcase
    end
  end

  assign row_len = (row_bytes_q == '0) ? POS_W'(1) :
                   (row_bytes_q > CFG_DATA_W'(MAX_ROW_BYTES)) ? POS_W'(MAX_ROW_BYTES) :
                   POS_W'(row_bytes_q);
  assign bpp_eff = (bpp_q == '0) ? BPP_W'(1) :
                   (bpp_q > BPP_W'(MAX_PIXEL_BYTES)) ? BPP_W'(MAX_PIXEL_BYTES) : bpp_q;

  pru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_first_i (s_axis_tuser_i[0]),
    .row_len_i  (row_len),
    .bpp_i      (bpp_eff),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  pru_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  pru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .bpp_i       (bpp_eff),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o    = res.raw;
  assign m_axis_tlast_o    = res.last;
  assign m_axis_tuser_o[0] = res.bad;

endmodule

// ===== rtl/pru_checker.sv =====
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks of the row unfilter, bound to the top level.
// ----------------------------------------------------------------------------
`include "png_row_unfilter_assert.svh"

module pru_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [0:0] m_axis_tuser_o
);

  `PRU_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni,
                  m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `PRU_ASSERT_NXT(a_out_data_hold, clk_i, rst_ni,
                  m_axis_tvalid_o && !m_axis_tready_i,
                  $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  `PRU_ASSERT_IMP(a_bad_is_zero, clk_i, rst_ni,
                  m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == 8'd0)
  `PRU_ASSERT_IMP(a_backpressure_src, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o)

endmodule

bind png_row_unfilter pru_checker u_pru_checker (.*);

// ===== tb/png_row_unfilter_tb.sv =====
// ----------------------------------------------------------------------------
// png_row_unfilter_tb
// Self-checking bench for the PNG row unfilter. Sends tagged rows over the
// slave stream and rebuilds every raw byte in a local line-store predictor.
// Each master transaction is compared against the oldest pending byte.
// Covers all five filters, unknown tags, first-row handling, reset defaults,
// clamped row and pixel sizes, random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module png_row_unfilter_tb;
  import pru_pkg::*;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EDGE} fill_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i = '0;
  logic [0:0]            s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [7:0]            m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  png_row_unfilter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  prior_row [MAX_ROW_BYTES];
  bit          prior_written [MAX_ROW_BYTES];
  int unsigned row_pos = 0;
  filt_e       row_kind = FILT_NONE;
  logic        row_bad = 1'b0;
  logic        row_first = 1'b1;
  logic [7:0]  left_bytes [MAX_PIXEL_BYTES];
  logic [7:0]  upleft_bytes [MAX_PIXEL_BYTES];
  logic [12:0] cfg_row_bytes = 13'd1;
  logic [3:0]  cfg_pixel_bytes = 4'd1;

  result_t     raw_expected [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;

  function automatic int unsigned eff_row_len();
    if (cfg_row_bytes == 0) return 1;
    if (cfg_row_bytes > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return cfg_row_bytes;
  endfunction

  function automatic void rebuild_byte(input logic [7:0] d, input logic f);
    int unsigned len, bpp, i;
    int          p, pa, pb, pc;
    logic [7:0]  up, a, c, pred, raw;
    result_t     r;
    len = eff_row_len();
    bpp = (cfg_pixel_bytes == 0) ? 1 :
          (cfg_pixel_bytes > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : cfg_pixel_bytes;
    if (row_pos == 0) begin
      if (d >= TAG_NONE && d <= TAG_PAETH) begin
        row_kind = filt_e'(d[2:0]);
        row_bad  = 1'b0;
      end else begin
        row_kind = FILT_NONE;
        row_bad  = 1'b1;
      end
      row_first = f;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_bytes[k]   = '0;
        upleft_bytes[k] = '0;
      end
      row_pos = 1;
      return;
    end
    i = row_pos - 1;
    if (i >= MAX_ROW_BYTES) i = MAX_ROW_BYTES - 1;
    up = row_first ? 8'd0 : prior_row[i];
    a  = (i >= bpp) ? left_bytes[bpp-1] : 8'd0;
    c  = (i >= bpp) ? upleft_bytes[bpp-1] : 8'd0;
    case (row_kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((9'(a) + 9'(up)) >> 1);
      FILT_PAETH: begin
        p  = int'(a) + int'(up) - int'(c);
        pa = (p >= int'(a))  ? p - int'(a)  : int'(a) - p;
        pb = (p >= int'(up)) ? p - int'(up) : int'(up) - p;
        pc = (p >= int'(c))  ? p - int'(c)  : int'(c) - p;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = up;
        else pred = c;
      end
      default:    pred = 8'd0;
    endcase
    raw = d + pred;
    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      upleft_bytes[k] = upleft_bytes[k-1];
      left_bytes[k]   = left_bytes[k-1];
    end
    upleft_bytes[0] = up;
    if (row_bad) begin
      raw = 8'd0;
      left_bytes[0] = 8'd0;
    end else begin
      left_bytes[0] = raw;
      prior_row[i] = raw;
      prior_written[i] = 1'b1;
    end
    r.raw  = raw;
    r.last = (i + 1 >= len);
    r.bad  = row_bad;
    raw_expected.push_back(r);
    row_pos = r.last ? 0 : i + 2;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin : drive_ready
    int hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (raw_expected.size() == 0) begin
        $error("unexpected raw_byte %0h with nothing pending", m_axis_tdata_o);
        error_count++;
      end else begin
        want = raw_expected.pop_front();
        if (m_axis_tdata_o !== want.raw) begin
          $error("raw_byte expected %0h got %0h", want.raw, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("end_of_row expected %0b got %0b", want.last, m_axis_tlast_o);
          error_count++;
        end
        if (m_axis_tuser_o[0] !== want.bad) begin
          $error("bad_filter expected %0b got %0b", want.bad, m_axis_tuser_o[0]);
          error_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= f;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rebuild_byte(d, f);
  endtask

  task automatic send_row(input logic [7:0] tag, input logic first_req, input fill_e fill);
    int unsigned len;
    logic        f;
    logic [7:0]  d;
    len = eff_row_len();
    f = first_req;
    for (int k = 0; k < len; k++) begin
      if (!prior_written[k]) f = 1'b1;
    end
    send_byte(tag, f);
    for (int k = 0; k < len; k++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hff;
        FILL_EDGE: d = ($urandom_range(1) == 1) ? 8'hff : 8'($urandom_range(1) * 8'h80);
        default:   d = 8'($urandom_range(255));
      endcase
      send_byte(d, 1'($urandom_range(1)));
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (raw_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [12:0] rb, input logic [3:0] bpp);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ROW_BYTES;
    cfg_data_i  <= rb;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_row_bytes = rb;
    cfg_index_i <= CFG_PIXEL_BYTES;
    cfg_data_i  <= 13'(bpp);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_pixel_bytes = bpp;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_row(TAG_NONE + 8'(FILT_SUB), 1'b1, FILL_EDGE);
    wait_drain();
  endtask

  task automatic test_each_filter();
    write_cfg(13'd3, 4'd1);
    send_row(TAG_NONE, 1'b1, FILL_EDGE);
    send_row(TAG_NONE + 8'(FILT_SUB), 1'b0, FILL_ONES);
    send_row(TAG_NONE + 8'(FILT_UP), 1'b0, FILL_ONES);
    send_row(TAG_NONE + 8'(FILT_AVG), 1'b0, FILL_EDGE);
    send_row(TAG_PAETH, 1'b0, FILL_ZERO);
    send_row(8'hff, 1'b0, FILL_ONES);
    wait_drain();
  endtask

  task automatic test_random_rows();
    int         sent;
    logic [7:0] tag;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 69;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct = 8;
        end
      endcase
      for (int rnd = 0; rnd < 3; rnd++) begin
        write_cfg(($urandom_range(7) == 0) ? 13'($urandom_range(40, 100))
                                           : 13'($urandom_range(1, 16)),
                  ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                           : 4'($urandom_range(1, 8)));
        sent = 0;
        while (sent < 80) begin
          if ($urandom_range(11) == 0) begin
            do tag = 8'($urandom_range(255)); while (tag inside {[TAG_NONE:TAG_PAETH]});
          end else begin
            tag = TAG_NONE + 8'($urandom_range(4));
          end
          send_row(tag, ($urandom_range(3) == 0),
                   ($urandom_range(3) == 0) ? FILL_EDGE : FILL_RANDOM);
          sent += eff_row_len() + 1;
        end
        wait_drain();
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_cfg(13'd20, 4'd2);
    hold_request = 300;
    send_row(TAG_PAETH, 1'b0, FILL_RANDOM);
    send_row(TAG_NONE + 8'(FILT_AVG), 1'b0, FILL_RANDOM);
    send_row(TAG_NONE + 8'(FILT_SUB), 1'b0, FILL_RANDOM);
    wait_drain();
  endtask

  task automatic test_row_extremes();
    send_idle_pct = 8;
    stall_pct = 8;
    write_cfg(13'd0, 4'd0);
    for (int k = 0; k < 6; k++) begin
      send_row(TAG_NONE + 8'(k % 5), 1'($urandom_range(1)), FILL_RANDOM);
    end
    wait_drain();
    write_cfg(13'd24, 4'd15);
    send_row(TAG_NONE + 8'(FILT_SUB), 1'b1, FILL_RANDOM);
    send_row(TAG_PAETH, 1'b0, FILL_EDGE);
    wait_drain();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_each_filter();
    test_random_rows();
    test_backpressure();
    test_row_extremes();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && raw_expected.size() == 0) begin
      $display("[png_row_unfilter] OK");
    end else begin
      $display("[png_row_unfilter] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[png_row_unfilter] ERROR");
    $finish;
  end

endmodule
